// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the 64-bit Murmur hash block.
// Depends on nothing; expects clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hw/rtl/mh64a_pkg.sv =====
// Constants, types and helper functions of the 64-bit Murmur hash block.
// Depends on nothing; imported by murmur_hash_64a_top, mh64a_hash_check and testbench.
package mh64a_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned HALF_W  = WORD_W / 2;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned BYTES   = WORD_W / 8;
	localparam int unsigned SDATA_W = 104;
	localparam int unsigned SHIFT   = 47;

	localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
	localparam logic [WORD_W-1:0] SEED_RESET = 64'h00000000c70f6907;
	localparam logic [HALF_W-1:0] MUL_LO     = MIX_MUL[HALF_W-1:0];
	localparam logic [HALF_W-1:0] MUL_HI     = MIX_MUL[WORD_W-1:HALF_W];
	localparam logic [CNT_W-1:0]  CNT_FULL   = 4'd8;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEN,
		ST_DISP,
		ST_K1,
		ST_K2,
		ST_H,
		ST_FIN
	} state_t;

	function automatic logic [WORD_W-1:0] spread(input logic [WORD_W-1:0] v);
		return v ^ (v >> SHIFT);
	endfunction

	function automatic logic [WORD_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < BYTES; i++) begin
			if (CNT_W'(i) < cnt) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/murmur_hash_64a_top.sv =====
// 64-bit Murmur hash (64A) over a stream of little-endian 8-byte words.
// Depends on mh64a_pkg and assert_macros.svh.
//
// One word is taken at a time; s_tready is low while it is worked on. Every
// 64-bit product with the mixing constant runs through one shared 32x32
// multiplier as three partial products. A word passes the dispatch state and
// then one multiply per product: one more on the first word (length times
// constant), three for a full word, one for a tail word of 1 to 7 bytes, and
// one more on the last word for finalization. The result waits in an output
// register, so the next word is accepted while it is still unclaimed.
`include "assert_macros.svh"

module murmur_hash_64a_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// data_word [63:0], valid_bytes [67:64], total_length [99:68], zero [103:100]
	input  logic [mh64a_pkg::SDATA_W-1:0]    s_tdata,
	// first_word [0]
	input  logic                             s_tuser,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// hash_value [63:0]
	output logic [mh64a_pkg::WORD_W-1:0]     m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mh64a_pkg::WORD_W-1:0]     cfg_data
);
	import mh64a_pkg::*;

	state_t              state_q, state_d;
	phase_t              ph_q, ph_d;
	logic [WORD_W-1:0]   seed_q, h_q, a_q, word_q, acc_q, prod_q, out_q;
	logic [CNT_W-1:0]    cnt_q, cnt_in;
	logic                last_q, out_valid_q;
	logic                mul_act, out_free, fin_done, accept;
	logic [HALF_W-1:0]   mul_a, mul_b;
	logic [WORD_W-1:0]   prod_d, mul_res;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign cnt_in    = (s_tdata[67:64] > CNT_FULL) ? CNT_FULL : s_tdata[67:64];
	assign mul_res   = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
	assign prod_d    = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = s_tuser ? ST_LEN : ST_DISP;
				end
			end
			ST_LEN: begin
				if (ph_q == PH_LAST) state_d = ST_DISP;
			end
			ST_DISP: begin
				if (cnt_q >= CNT_FULL) state_d = ST_K1;
				else if (cnt_q != '0) state_d = ST_H;
				else if (last_q) state_d = ST_FIN;
				else state_d = ST_IDLE;
			end
			ST_K1: begin
				if (ph_q == PH_LAST) state_d = ST_K2;
			end
			ST_K2: begin
				if (ph_q == PH_LAST) state_d = ST_H;
			end
			ST_H: begin
				if (ph_q == PH_LAST) state_d = last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (ph_q == PH_LAST && out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mul_act  = 1'b0;
		fin_done = 1'b0;
		mul_a    = a_q[HALF_W-1:0];
		mul_b    = MUL_LO;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_LEN, ST_K1, ST_K2, ST_H: mul_act = 1'b1;
			ST_FIN: begin
				mul_act  = 1'b1;
				fin_done = (ph_q == PH_LAST) && out_free;
			end
			default: mul_act = 1'b0;
		endcase
		case (ph_q)
			2'd1: mul_a = a_q[WORD_W-1:HALF_W];
			2'd2: mul_b = MUL_HI;
			default: mul_a = a_q[HALF_W-1:0];
		endcase
		if (mul_act && ph_q != PH_LAST) ph_d = ph_q + 2'd1;
		else if (state_d != state_q) ph_d = '0;
		else ph_d = ph_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= '0;
			seed_q      <= SEED_RESET;
			h_q         <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			if (cfg_valid && cfg_ready) seed_q <= cfg_data;
			if (accept) last_q <= s_tlast;
			if (state_q == ST_LEN && ph_q == PH_LAST) h_q <= seed_q ^ mul_res;
			if (state_q == ST_H && ph_q == PH_LAST) h_q <= mul_res;
			if (fin_done) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= s_tdata[WORD_W-1:0];
			cnt_q  <= cnt_in;
		end
		if (mul_act && ph_q != PH_LAST) prod_q <= prod_d;
		if (mul_act && ph_q == 2'd1) acc_q <= prod_q;
		if (mul_act && ph_q == 2'd2) acc_q <= mul_res;
		case (state_q)
			ST_IDLE: if (accept) a_q <= {{(WORD_W-LEN_W){1'b0}}, s_tdata[99:68]};
			ST_DISP: begin
				if (cnt_q >= CNT_FULL) a_q <= word_q;
				else if (cnt_q != '0) a_q <= h_q ^ (word_q & byte_mask(cnt_q));
				else a_q <= spread(h_q);
			end
			ST_K1: if (ph_q == PH_LAST) a_q <= spread(mul_res);
			ST_K2: if (ph_q == PH_LAST) a_q <= h_q ^ mul_res;
			ST_H: if (ph_q == PH_LAST) a_q <= spread(mul_res);
			default: a_q <= a_q;
		endcase
		if (fin_done) out_q <= spread(mul_res);
	end

	`ASSERT_CLK(a_ph_rest, !mul_act |-> ph_q == '0, "phase not cleared outside multiply")
	`ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "ready again right after a beat")
	`ASSERT_CLK(a_fin_last, state_q == ST_FIN |-> last_q, "finalization without last beat")
	`ASSERT_CLK(a_out_from_fin, $rose(m_tvalid) |-> $past(state_q == ST_FIN), "stray result")

endmodule

// ===== tb/sv/mh64a_hash_check.sv =====
// Checker for the 64-bit Murmur hash block: watches the word, seed and hash channels,
// predicts every finished hash from its own copy of seed and running hash, and compares.
// Depends on mh64a_pkg for port and field widths.
module mh64a_hash_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// data_word [63:0], valid_bytes [67:64], total_length [99:68], zero [103:100]
	input  logic [mh64a_pkg::SDATA_W-1:0] s_tdata,
	// first_word [0]
	input  logic                          s_tuser,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// hash_value [63:0]
	input  logic [mh64a_pkg::WORD_W-1:0]  m_tdata,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [mh64a_pkg::WORD_W-1:0]  cfg_data,
	output int                            hashes_pending,
	output int                            mismatch_count,
	output int                            hashes_compared
);
	import mh64a_pkg::*;

	localparam logic [63:0] MURMUR_M     = 64'hc6a4a7935bd1e995;
	localparam logic [63:0] SEED_DEFAULT = 64'h00000000c70f6907;
	localparam int unsigned XSHIFT       = 47;

	logic [63:0] seed_now;
	logic [63:0] hash_acc;
	logic [63:0] hash_due[$];

	function automatic logic [63:0] fold(input logic [63:0] v);
		return v ^ (v >> XSHIFT);
	endfunction

	function automatic logic [63:0] absorb(input logic [63:0] acc, input logic [63:0] word,
			input logic [3:0] n);
		logic [63:0] k;
		logic [63:0] keep;
		if (n >= 4'd8) begin
			k = word * MURMUR_M;
			k = fold(k) * MURMUR_M;
			return (acc ^ k) * MURMUR_M;
		end
		if (n == 4'd0) begin
			return acc;
		end
		keep = ~(64'hffffffffffffffff << (8 * n));
		return (acc ^ (word & keep)) * MURMUR_M;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			seed_now = SEED_DEFAULT;
			hash_acc = '0;
			hash_due.delete();
			hashes_pending = 0;
			mismatch_count = 0;
			hashes_compared = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_now = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (hash_due.size() == 0) begin
					$display("%0t: unexpected hash: expected none, got %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = hash_due.pop_front();
					hashes_compared++;
					if (m_tdata !== want) begin
						$display("%0t: hash mismatch: expected %h, got %h", $time, want, m_tdata);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					hash_acc = seed_now ^ ({32'd0, s_tdata[WORD_W+CNT_W +: LEN_W]} * MURMUR_M);
				end
				hash_acc = absorb(hash_acc, s_tdata[WORD_W-1:0], s_tdata[WORD_W +: CNT_W]);
				if (s_tlast) begin
					hash_due.push_back(fold(fold(hash_acc) * MURMUR_M));
				end
			end
			hashes_pending = hash_due.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the 64-bit Murmur hash testbench: clock, reset, word and seed stimulus, verdict.
// Depends on mh64a_pkg, murmur_hash_64a_top and mh64a_hash_check.
module testbench;
	import mh64a_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 30;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [SDATA_W-1:0] s_tdata;
	logic               s_tuser;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [WORD_W-1:0]  m_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WORD_W-1:0]  cfg_data;
	int                 hashes_pending;
	int                 mismatch_count;
	int                 hashes_compared;
	int                 send_gap_pct;
	int                 recv_gap_pct;
	int                 beats_sent;
	int                 seeds_written;
	int                 cycle_count;

	murmur_hash_64a_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	mh64a_hash_check hash_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.hashes_pending  (hashes_pending),
		.mismatch_count  (mismatch_count),
		.hashes_compared (hashes_compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(99) >= recv_gap_pct);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(input logic [63:0] w, input logic [3:0] n, input logic first,
			input logic last, input logic [31:0] len);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, len, n, w};
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic send_message(input int nbytes, input logic [31:0] len_field);
		int left;
		logic [3:0] n;
		left = nbytes;
		if (nbytes == 0) begin
			send_beat(rand64(), 4'd0, 1'b1, 1'b1, len_field);
			return;
		end
		for (int i = 0; left > 0; i++) begin
			n = (left >= 8) ? 4'd8 : 4'(left);
			if (n == 4'd8 && $urandom_range(9) == 0) begin
				n = 4'($urandom_range(15, 9));
			end
			left -= 8;
			send_beat(rand64(), n, i == 0, left <= 0, len_field);
		end
	endtask

	// drop valid and hold until every hash is back and the block has gone quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (hashes_pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seeds_written++;
	endtask

	task automatic directed_cases();
		// continuation straight after reset starts from a zero hash
		send_beat(rand64(), 4'd8, 1'b0, 1'b1, 32'd0);
		send_beat(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);
		send_beat('1, 4'd1, 1'b1, 1'b1, 32'd1);
		send_beat('1, 4'd7, 1'b1, 1'b1, 32'd7);
		send_beat('0, 4'd8, 1'b1, 1'b1, 32'd8);
		send_beat('1, 4'd15, 1'b1, 1'b1, '1);
		send_beat(rand64(), 4'd9, 1'b1, 1'b0, 32'd16);
		send_beat(rand64(), 4'd8, 1'b0, 1'b1, 32'd16);
		send_beat(rand64(), 4'd8, 1'b0, 1'b1, 32'd0);
		// short and empty words at the start and in the middle of a message
		send_beat(rand64(), 4'd3, 1'b1, 1'b0, 32'd16);
		send_beat(rand64(), 4'd8, 1'b0, 1'b0, 32'd0);
		send_beat(rand64(), 4'd5, 1'b0, 1'b1, 32'd0);
		send_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd12);
		send_beat(rand64(), 4'd0, 1'b0, 1'b0, 32'd0);
		send_beat(rand64(), 4'd4, 1'b0, 1'b1, 32'd0);
		// restart in the middle of a message
		send_beat(rand64(), 4'd8, 1'b1, 1'b0, 32'd8);
		send_beat(rand64(), 4'd8, 1'b1, 1'b1, 32'd8);
		for (int n = 10; n <= 14; n++) begin
			send_beat(rand64(), 4'(n), n == 10, n == 14, 32'd40);
		end
	endtask

	task automatic random_traffic(input int target_beats);
		int stop_at;
		int nbytes;
		stop_at = beats_sent + target_beats;
		while (beats_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				send_beat(rand64(), 4'($urandom_range(15)), $urandom_range(3) == 0,
					$urandom_range(2) == 0, $urandom);
			end else begin
				nbytes = ($urandom_range(19) == 0) ? $urandom_range(160) : $urandom_range(40);
				send_message(nbytes, ($urandom_range(9) == 0) ? $urandom : 32'(nbytes));
			end
			if ($urandom_range(39) == 0) begin
				settle();
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		send_gap_pct = 22;
		recv_gap_pct = 74;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_cases();
		settle();
		write_seed('1);
		random_traffic(140);
		settle();

		send_gap_pct = 74;
		recv_gap_pct = 22;
		write_seed('0);
		random_traffic(150);
		settle();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_seed(rand64());
		random_traffic(75);
		settle();
		write_seed(rand64());
		random_traffic(75);
		settle();

		$display("covered %0d beats and %0d compared hashes under %0d seed writes,",
			beats_sent, hashes_compared, seeds_written);
		$display("reset seed and both seed extremes, three sender/receiver stall mixes");
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
